@@ hw/rtl/hcb_pkg.sv @@
// Shared constants and types for the Huffman code builder.
// No dependencies.
package hcb_pkg;
  localparam int SYMBOLS     = 32;
  localparam int WEIGHT_BITS = 16;
  localparam int NODES       = 2 * SYMBOLS - 1;
  localparam int IDX_W       = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int CNT_W       = $clog2(SYMBOLS + 1);
  localparam int NODE_W      = WEIGHT_BITS + CNT_W;
  localparam int IN_W        = 16;
  localparam int W_USE       = (WEIGHT_BITS < IN_W) ? WEIGHT_BITS : IN_W;
  localparam int SYM_W       = 6;
  localparam int LEN_W       = 6;
  localparam int CODE_W      = 63;

  // running two-least search, handed from cell to cell
  typedef struct packed {
    logic              go;
    logic              v1;
    logic [NODE_W-1:0] w1;
    logic [IDX_W-1:0]  i1;
    logic              v2;
    logic [NODE_W-1:0] w2;
    logic [IDX_W-1:0]  i2;
  } carry_t;

  // merge broadcast: a left, b right, new node k
  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  a;
    logic [IDX_W-1:0]  b;
    logic [IDX_W-1:0]  k;
    logic [NODE_W-1:0] sum;
  } merge_t;

  typedef struct packed {
    logic [IDX_W-1:0]  grp;
    logic [LEN_W-1:0]  len;
    logic [CODE_W-1:0] bits;
  } leaf_t;
endpackage

@@ hw/rtl/hcb_cell.sv @@
// One tree node cell: holds weight and free flag, updates the passing search.
// Depends on hcb_pkg.
module hcb_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [hcb_pkg::IDX_W-1:0]  idx,
  input  logic                       load_en,
  input  logic                       clear_en,
  input  logic [hcb_pkg::NODE_W-1:0] load_weight,
  input  hcb_pkg::merge_t            merge,
  input  hcb_pkg::carry_t            cin,
  output hcb_pkg::carry_t            cout
);
  logic [hcb_pkg::NODE_W-1:0] weight;
  logic                       free;
  hcb_pkg::carry_t            c_next;

  always_comb begin
    c_next = cin;
    if (cin.go && free) begin
      if (!cin.v1 || weight < cin.w1) begin
        c_next.v2 = cin.v1;
        c_next.w2 = cin.w1;
        c_next.i2 = cin.i1;
        c_next.v1 = 1'b1;
        c_next.w1 = weight;
        c_next.i1 = idx;
      end else if (!cin.v2 || weight < cin.w2) begin
        c_next.v2 = 1'b1;
        c_next.w2 = weight;
        c_next.i2 = idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free    <= 1'b0;
      cout.go <= 1'b0;
    end else begin
      cout.go <= c_next.go;
      if (load_en) begin
        free <= 1'b1;
      end else if (clear_en) begin
        free <= 1'b0;
      end else if (merge.en) begin
        if (idx == merge.k) begin
          free <= 1'b1;
        end else if (idx == merge.a || idx == merge.b) begin
          free <= 1'b0;
        end
      end
    end
    cout.v1 <= c_next.v1;
    cout.w1 <= c_next.w1;
    cout.i1 <= c_next.i1;
    cout.v2 <= c_next.v2;
    cout.w2 <= c_next.w2;
    cout.i2 <= c_next.i2;
    if (load_en) begin
      weight <= load_weight;
    end else if (merge.en && idx == merge.k) begin
      weight <= merge.sum;
    end
  end
endmodule

@@ hw/rtl/hcb_leaf.sv @@
// One symbol cell: tracks its subtree root, grows its code when that root merges.
// Shifts toward cell 0 during code output. Depends on hcb_pkg.
module hcb_leaf (
  input  logic                      clk,
  input  logic [hcb_pkg::IDX_W-1:0] idx,
  input  logic                      load_en,
  input  hcb_pkg::merge_t           merge,
  input  logic                      shift_en,
  input  hcb_pkg::leaf_t            lin,
  output hcb_pkg::leaf_t            lout
);
  always_ff @(posedge clk) begin
    if (load_en) begin
      lout.grp  <= idx;
      lout.len  <= '0;
      lout.bits <= '0;
    end else if (shift_en) begin
      lout <= lin;
    end else if (merge.en) begin
      if (lout.grp == merge.a) begin
        lout.grp <= merge.k;
        lout.len <= lout.len + 1'b1;
      end else if (lout.grp == merge.b) begin
        lout.grp  <= merge.k;
        lout.len  <= lout.len + 1'b1;
        lout.bits <= lout.bits | (hcb_pkg::CODE_W'(1) << lout.len);
      end
    end
  end
endmodule

@@ hw/rtl/huffman_code_builder.sv @@
// Top level of the Huffman code builder: control, node cell row, symbol cell row.
// Depends on hcb_pkg, hcb_cell, hcb_leaf.
//
//  channel | valid     | stall     | fields
//  input   | in_valid  | in_stall  | weight, last
//  output  | out_valid | out_stall | symbol, code_length, code_bits, final_code
//
// Weights load at one per cycle. After the final weight, each of the n-1
// merges sends a search token once along the node cell row. Codes then leave
// at one per cycle unless the output stalls, the symbol row shifting to cell 0.
// Reset is synchronous; output stalls hold the result register and the row.
module huffman_code_builder (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [hcb_pkg::IN_W-1:0]    weight,
  input  logic                        last,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [hcb_pkg::SYM_W-1:0]   symbol,
  output logic [hcb_pkg::LEN_W-1:0]   code_length,
  output logic [hcb_pkg::CODE_W-1:0]  code_bits,
  output logic                        final_code
);
  localparam logic [1:0] ST_LOAD = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]                 state;
  logic [hcb_pkg::CNT_W-1:0]  count;
  logic [hcb_pkg::CNT_W-1:0]  emit_cnt;
  logic [hcb_pkg::IDX_W-1:0]  k;
  logic                       inject;
  logic                       take;
  logic                       final_in;
  logic                       emit_now;
  logic [hcb_pkg::NODE_W-1:0] load_weight;
  hcb_pkg::merge_t            merge;
  hcb_pkg::carry_t            chain [0:hcb_pkg::NODES];
  hcb_pkg::leaf_t             leaves [0:hcb_pkg::SYMBOLS];

  assign in_stall    = (state != ST_LOAD);
  assign take        = in_valid && !in_stall;
  assign final_in    = last || (count == hcb_pkg::CNT_W'(hcb_pkg::SYMBOLS - 1));
  assign load_weight = hcb_pkg::NODE_W'(weight[hcb_pkg::W_USE-1:0]);
  assign emit_now    = (state == ST_EMIT) && (!out_valid || !out_stall);

  assign chain[0] = {inject, {($bits(hcb_pkg::carry_t) - 1){1'b0}}};
  assign leaves[hcb_pkg::SYMBOLS] = '0;

  always_comb begin
    merge.en  = (state == ST_SCAN) && chain[hcb_pkg::NODES].go;
    merge.a   = chain[hcb_pkg::NODES].i1;
    merge.b   = chain[hcb_pkg::NODES].i2;
    merge.k   = k;
    merge.sum = chain[hcb_pkg::NODES].w1 + chain[hcb_pkg::NODES].w2;
  end

  for (genvar i = 0; i < hcb_pkg::NODES; i++) begin : g_cell
    hcb_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .idx        (hcb_pkg::IDX_W'(i)),
      .load_en    (take && count == hcb_pkg::CNT_W'(i)),
      .clear_en   (take && count == '0),
      .load_weight(load_weight),
      .merge      (merge),
      .cin        (chain[i]),
      .cout       (chain[i+1])
    );
  end

  for (genvar i = 0; i < hcb_pkg::SYMBOLS; i++) begin : g_leaf
    hcb_leaf u_leaf (
      .clk     (clk),
      .idx     (hcb_pkg::IDX_W'(i)),
      .load_en (take && count == hcb_pkg::CNT_W'(i)),
      .merge   (merge),
      .shift_en(emit_now),
      .lin     (leaves[i+1]),
      .lout    (leaves[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      count     <= '0;
      emit_cnt  <= '0;
      inject    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      inject <= 1'b0;
      if (out_valid && !out_stall && !emit_now) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_LOAD: begin
          if (take) begin
            count <= count + 1'b1;
            if (final_in) begin
              emit_cnt <= '0;
              if (count == '0) begin
                state <= ST_EMIT;
              end else begin
                state  <= ST_SCAN;
                k      <= hcb_pkg::IDX_W'(count + 1'b1);
                inject <= 1'b1;
              end
            end
          end
        end
        ST_SCAN: begin
          if (merge.en) begin
            if (k == hcb_pkg::IDX_W'(2 * count - 2)) begin
              state <= ST_EMIT;
            end else begin
              k      <= k + 1'b1;
              inject <= 1'b1;
            end
          end
        end
        ST_EMIT: begin
          if (emit_now) begin
            out_valid   <= 1'b1;
            symbol      <= hcb_pkg::SYM_W'(emit_cnt);
            code_length <= leaves[0].len;
            code_bits   <= leaves[0].bits;
            final_code  <= (emit_cnt + 1'b1 == count);
            emit_cnt    <= emit_cnt + 1'b1;
            if (emit_cnt + 1'b1 == count) begin
              state <= ST_LOAD;
              count <= '0;
            end
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end
endmodule
